### rtl/l2e_pkg.sv
package l2e_pkg;

	localparam int IMAGE_WIDTH_DEF  = 4096;
	localparam int IMAGE_HEIGHT_DEF = 2048;

	localparam logic signed [31:0] Q28_ONE     = 32'sd268435456;
	localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;
	localparam logic [29:0]        HALF_PI2    = 30'd843314856;
	localparam logic [30:0]        INV_TWO_PI  = 31'd683565276;
	localparam logic [19:0]        OUT_MAX     = 20'hFFFFF;

	typedef enum logic [2:0] {
		CFG_CENTRE_X    = 3'd0,
		CFG_CENTRE_Y    = 3'd1,
		CFG_INV_FOCAL_X = 3'd2,
		CFG_INV_FOCAL_Y = 3'd3,
		CFG_RADIAL_K1   = 3'd4,
		CFG_RADIAL_K2   = 3'd5,
		CFG_RADIAL_K3   = 3'd6,
		CFG_RADIAL_K4   = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [20:0]        centre_x;
		logic [20:0]        centre_y;
		logic [31:0]        inv_focal_x;
		logic [31:0]        inv_focal_y;
		logic signed [31:0] radial_k1;
		logic signed [31:0] radial_k2;
		logic signed [31:0] radial_k3;
		logic signed [31:0] radial_k4;
	} lens_cfg_t;

	localparam lens_cfg_t CFG_RESET = '{
		centre_x:    21'd0,
		centre_y:    21'd262144,
		inv_focal_x: 32'd1647099,
		inv_focal_y: 32'd1647099,
		radial_k1:   32'sd0,
		radial_k2:   32'sd0,
		radial_k3:   32'sd0,
		radial_k4:   32'sd0
	};

	typedef struct packed {
		logic signed [31:0] nx;
		logic signed [31:0] ny;
	} norm_t;

	typedef struct packed {
		logic signed [31:0] nx;
		logic signed [31:0] ny;
		logic signed [31:0] radial;
	} poly_t;

	typedef struct packed {
		logic [19:0] map_x;
		logic [19:0] map_y;
		logic        lat_clamped;
	} res_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end else if (v < -64'sd2147483648) begin
			return 32'sh80000000;
		end else begin
			return v[31:0];
		end
	endfunction

	// q.56 product back to q4.28, round half up, saturate
	function automatic logic signed [31:0] rnd28(input logic signed [63:0] v);
		logic signed [63:0] t;
		t = v + 64'sd134217728;
		return sat32(t >>> 28);
	endfunction

endpackage

### rtl/l2e_norm.sv
module l2e_norm (
	input  logic                    clk,
	input  logic                    arst_n,
	input  l2e_pkg::lens_cfg_t      cfg,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [20:0]             point_x,
	input  logic [20:0]             point_y,
	output logic                    out_valid,
	input  logic                    out_ready,
	output l2e_pkg::norm_t          out_data
);

	localparam int NS = 2;

	logic [NS:1]   vld_q;
	logic [NS+1:1] en;
	logic [NS:1]   vld_nxt;

	logic signed [21:0] dx, dy;
	logic signed [54:0] px_s1, py_s1;
	logic signed [31:0] nx_s2, ny_s2;

	function automatic logic signed [31:0] norm_q28(input logic signed [54:0] v);
		logic signed [55:0] t;
		t = 56'(v) + 56'sd512;
		return l2e_pkg::sat32(64'(t >>> 10));
	endfunction

	always_comb begin
		en[NS+1] = out_ready;
		for (int i = NS; i >= 1; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	assign vld_nxt   = {vld_q[NS-1:1], in_valid};
	assign in_ready  = en[1];
	assign out_valid = vld_q[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 1; i <= NS; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_nxt[i];
				end
			end
		end
	end

	assign dx = $signed({1'b0, point_x}) - $signed({1'b0, cfg.centre_x});
	assign dy = $signed({1'b0, point_y}) - $signed({1'b0, cfg.centre_y});

	always_ff @(posedge clk) begin
		if (en[1]) begin
			px_s1 <= 55'(dx) * 55'($signed({1'b0, cfg.inv_focal_x}));
			py_s1 <= 55'(dy) * 55'($signed({1'b0, cfg.inv_focal_y}));
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			nx_s2 <= norm_q28(px_s1);
			ny_s2 <= norm_q28(py_s1);
		end
	end

	assign out_data.nx = nx_s2;
	assign out_data.ny = ny_s2;

endmodule

### rtl/l2e_poly.sv
module l2e_poly (
	input  logic                    clk,
	input  logic                    arst_n,
	input  l2e_pkg::lens_cfg_t      cfg,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  l2e_pkg::norm_t          in_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output l2e_pkg::poly_t          out_data
);

	localparam int NS = 8;

	logic [NS:1]   vld_q;
	logic [NS+1:1] en;
	logic [NS:1]   vld_nxt;

	l2e_pkg::norm_t pt_s1, pt_s2, pt_s3, pt_s4, pt_s5, pt_s6, pt_s7, pt_s8;

	logic signed [63:0] sqx_s1, sqy_s1;
	logic signed [31:0] r2_s2;
	logic signed [31:0] r2_s3;
	logic signed [63:0] rr_s3, k1p_s3;
	logic signed [31:0] r2_s4, r4_s4, t1_s4;
	logic signed [31:0] t1_s5;
	logic signed [63:0] r6p_s5, r8p_s5, k2p_s5;
	logic signed [31:0] r6_s6, r8_s6;
	logic signed [34:0] acc_s6;
	logic signed [34:0] acc_s7;
	logic signed [63:0] k3p_s7, k4p_s7;
	logic signed [31:0] radial_s8;

	always_comb begin
		en[NS+1] = out_ready;
		for (int i = NS; i >= 1; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	assign vld_nxt   = {vld_q[NS-1:1], in_valid};
	assign in_ready  = en[1];
	assign out_valid = vld_q[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 1; i <= NS; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_nxt[i];
				end
			end
		end
	end

	// squares of the normalized point
	always_ff @(posedge clk) begin
		if (en[1]) begin
			pt_s1  <= in_data;
			sqx_s1 <= 64'(in_data.nx) * 64'(in_data.nx);
			sqy_s1 <= 64'(in_data.ny) * 64'(in_data.ny);
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			pt_s2 <= pt_s1;
			r2_s2 <= l2e_pkg::sat32(64'(l2e_pkg::rnd28(sqx_s1)) + 64'(l2e_pkg::rnd28(sqy_s1)));
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			pt_s3  <= pt_s2;
			r2_s3  <= r2_s2;
			rr_s3  <= 64'(r2_s2) * 64'(r2_s2);
			k1p_s3 <= 64'(cfg.radial_k1) * 64'(r2_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			pt_s4 <= pt_s3;
			r2_s4 <= r2_s3;
			r4_s4 <= l2e_pkg::rnd28(rr_s3);
			t1_s4 <= l2e_pkg::rnd28(k1p_s3);
		end
	end

	always_ff @(posedge clk) begin
		if (en[5]) begin
			pt_s5  <= pt_s4;
			t1_s5  <= t1_s4;
			r6p_s5 <= 64'(r4_s4) * 64'(r2_s4);
			r8p_s5 <= 64'(r4_s4) * 64'(r4_s4);
			k2p_s5 <= 64'(cfg.radial_k2) * 64'(r4_s4);
		end
	end

	// partial sum stays unsaturated, only the full sum saturates
	always_ff @(posedge clk) begin
		if (en[6]) begin
			pt_s6  <= pt_s5;
			r6_s6  <= l2e_pkg::rnd28(r6p_s5);
			r8_s6  <= l2e_pkg::rnd28(r8p_s5);
			acc_s6 <= 35'(l2e_pkg::Q28_ONE) + 35'(t1_s5) + 35'(l2e_pkg::rnd28(k2p_s5));
		end
	end

	always_ff @(posedge clk) begin
		if (en[7]) begin
			pt_s7  <= pt_s6;
			acc_s7 <= acc_s6;
			k3p_s7 <= 64'(cfg.radial_k3) * 64'(r6_s6);
			k4p_s7 <= 64'(cfg.radial_k4) * 64'(r8_s6);
		end
	end

	always_ff @(posedge clk) begin
		if (en[8]) begin
			pt_s8     <= pt_s7;
			radial_s8 <= l2e_pkg::sat32(64'(acc_s7) + 64'(l2e_pkg::rnd28(k3p_s7))
				+ 64'(l2e_pkg::rnd28(k4p_s7)));
		end
	end

	assign out_data.nx     = pt_s8.nx;
	assign out_data.ny     = pt_s8.ny;
	assign out_data.radial = radial_s8;

endmodule

### rtl/l2e_map.sv
module l2e_map #(
	parameter int IMAGE_WIDTH  = l2e_pkg::IMAGE_WIDTH_DEF,
	parameter int IMAGE_HEIGHT = l2e_pkg::IMAGE_HEIGHT_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  l2e_pkg::poly_t          in_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output l2e_pkg::res_t           out_data
);

	localparam int NS = 6;

	// map_y = u * YM / HALF_PI2, done as u * YR >> 32 with one correction step
	localparam logic [63:0] YM = 64'(IMAGE_HEIGHT) * 64'd256;
	localparam logic [63:0] YR = (YM << 32) / 64'(l2e_pkg::HALF_PI2);
	localparam int          MB = $clog2(YM + 64'd1);
	localparam int          RB = $clog2(YR + 64'd1);
	localparam int          WB = $clog2(IMAGE_WIDTH + 1);
	localparam int          PW = 30 + MB;

	logic [NS:1]   vld_q;
	logic [NS+1:1] en;
	logic [NS:1]   vld_nxt;

	logic signed [63:0] thp_s1, php_s1;
	logic signed [31:0] theta_s2, phi_s2;
	logic signed [62:0] turns;
	logic signed [32:0] phi_off;
	logic signed [31:0] phi_c;
	logic               clp;
	logic [31:0]        frac_s3;
	logic [29:0]        u_s3;
	logic               clp_s3;
	logic [32+WB-1:0]   mxp_s4;
	logic [30+RB-1:0]   uyp_s4;
	logic [29:0]        u_s4;
	logic               clp_s4;
	logic [63:0]        mxw;
	logic [MB-1:0]      q_est;
	logic [19:0]        mx_s5;
	logic [MB-1:0]      q_s5;
	logic [PW-1:0]      um_s5, qd_s5;
	logic               clp_s5;
	logic [PW-1:0]      rem;
	logic [MB:0]        qc;
	l2e_pkg::res_t      res_s6;

	always_comb begin
		en[NS+1] = out_ready;
		for (int i = NS; i >= 1; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	assign vld_nxt   = {vld_q[NS-1:1], in_valid};
	assign in_ready  = en[1];
	assign out_valid = vld_q[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 1; i <= NS; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_nxt[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			thp_s1 <= 64'(in_data.nx) * 64'(in_data.radial);
			php_s1 <= 64'(in_data.ny) * 64'(in_data.radial);
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			theta_s2 <= l2e_pkg::rnd28(thp_s1);
			phi_s2   <= l2e_pkg::rnd28(php_s1);
		end
	end

	// turns in q.60, fraction of a turn is bits 59:28 (negatives wrap upward)
	assign turns = 63'(theta_s2) * 63'($signed({1'b0, l2e_pkg::INV_TWO_PI}));

	always_comb begin
		clp   = 1'b0;
		phi_c = phi_s2;
		if (phi_s2 > l2e_pkg::HALF_PI_Q28) begin
			phi_c = l2e_pkg::HALF_PI_Q28;
			clp   = 1'b1;
		end else if (phi_s2 < -l2e_pkg::HALF_PI_Q28) begin
			phi_c = -l2e_pkg::HALF_PI_Q28;
			clp   = 1'b1;
		end
	end

	assign phi_off = 33'(phi_c) + 33'(l2e_pkg::HALF_PI_Q28);

	always_ff @(posedge clk) begin
		if (en[3]) begin
			frac_s3 <= turns[59:28];
			u_s3    <= phi_off[29:0];
			clp_s3  <= clp;
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			mxp_s4 <= (32+WB)'(frac_s3) * (32+WB)'(IMAGE_WIDTH);
			uyp_s4 <= (30+RB)'(u_s3) * (30+RB)'(YR);
			u_s4   <= u_s3;
			clp_s4 <= clp_s3;
		end
	end

	assign mxw   = 64'(mxp_s4) >> 24;
	assign q_est = MB'(64'(uyp_s4) >> 32);

	always_ff @(posedge clk) begin
		if (en[5]) begin
			mx_s5  <= (mxw > 64'(l2e_pkg::OUT_MAX)) ? l2e_pkg::OUT_MAX : mxw[19:0];
			q_s5   <= q_est;
			um_s5  <= PW'(u_s4) * PW'(YM);
			qd_s5  <= PW'(q_est) * PW'(l2e_pkg::HALF_PI2);
			clp_s5 <= clp_s4;
		end
	end

	// estimate is low by at most one
	assign rem = um_s5 - qd_s5;
	assign qc  = (MB+1)'(q_s5) + (MB+1)'(rem >= PW'(l2e_pkg::HALF_PI2));

	always_ff @(posedge clk) begin
		if (en[6]) begin
			res_s6.map_x       <= mx_s5;
			res_s6.map_y       <= (64'(qc) > 64'(l2e_pkg::OUT_MAX)) ? l2e_pkg::OUT_MAX
				: 20'(qc);
			res_s6.lat_clamped <= clp_s5;
		end
	end

	assign out_data = res_s6;

endmodule

### rtl/lens_to_equirect_mapper_core.sv
// each input transfer goes through norm, poly and map to the output stream
// throughput: one point per cycle; each of the 16 stages holds or passes its item,
// and bubbles close up, so input stalls only when every stage holds an item
// reset: all stage valid bits clear at once, lens registers return to the default
// equirectangular lens (centre 0/1024, inverse focal 2*pi/4096, no radial terms)
module lens_to_equirect_mapper_core #(
	parameter int IMAGE_WIDTH  = l2e_pkg::IMAGE_WIDTH_DEF,
	parameter int IMAGE_HEIGHT = l2e_pkg::IMAGE_HEIGHT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // point_x [20:0], point_y [41:21], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // map_x [19:0], map_y [39:20]
	output logic [0:0]  m_tuser,   // lat_clamped [0]
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [31:0] cfg_data
);

	l2e_pkg::lens_cfg_t cfg_q;
	l2e_pkg::norm_t     norm_data;
	l2e_pkg::poly_t     poly_data;
	l2e_pkg::res_t      res_data;
	logic               norm_valid, norm_ready;
	logic               poly_valid, poly_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= l2e_pkg::CFG_RESET;
		end else if (cfg_we) begin
			case (l2e_pkg::cfg_idx_t'(cfg_idx))
				l2e_pkg::CFG_CENTRE_X:    cfg_q.centre_x    <= cfg_data[20:0];
				l2e_pkg::CFG_CENTRE_Y:    cfg_q.centre_y    <= cfg_data[20:0];
				l2e_pkg::CFG_INV_FOCAL_X: cfg_q.inv_focal_x <= cfg_data;
				l2e_pkg::CFG_INV_FOCAL_Y: cfg_q.inv_focal_y <= cfg_data;
				l2e_pkg::CFG_RADIAL_K1:   cfg_q.radial_k1   <= cfg_data;
				l2e_pkg::CFG_RADIAL_K2:   cfg_q.radial_k2   <= cfg_data;
				l2e_pkg::CFG_RADIAL_K3:   cfg_q.radial_k3   <= cfg_data;
				l2e_pkg::CFG_RADIAL_K4:   cfg_q.radial_k4   <= cfg_data;
				default:                  cfg_q             <= cfg_q;
			endcase
		end
	end

	l2e_norm u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.point_x   (s_tdata[20:0]),
		.point_y   (s_tdata[41:21]),
		.out_valid (norm_valid),
		.out_ready (norm_ready),
		.out_data  (norm_data)
	);

	l2e_poly u_poly (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (norm_valid),
		.in_ready  (norm_ready),
		.in_data   (norm_data),
		.out_valid (poly_valid),
		.out_ready (poly_ready),
		.out_data  (poly_data)
	);

	l2e_map #(
		.IMAGE_WIDTH  (IMAGE_WIDTH),
		.IMAGE_HEIGHT (IMAGE_HEIGHT)
	) u_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (poly_valid),
		.in_ready  (poly_ready),
		.in_data   (poly_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (res_data)
	);

	assign m_tdata = {res_data.map_y, res_data.map_x};
	assign m_tuser = res_data.lat_clamped;

`ifndef SYNTH
	// an empty output stage means every stage can move
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output stage");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output drains");

	// a clamped latitude lands on the top or bottom row
	a_clamp_edge: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata[39:20] == 20'd0 ||
			64'(m_tdata[39:20]) == ((64'(IMAGE_HEIGHT) * 64'd256 > 64'hFFFFF) ?
			64'hFFFFF : 64'(IMAGE_HEIGHT) * 64'd256)))
		else $error("clamped latitude off the image edge");

	a_map_y_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> 64'(m_tdata[39:20]) <= 64'(IMAGE_HEIGHT) * 64'd256)
		else $error("map_y beyond image height");

	a_map_x_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> 64'(m_tdata[19:0]) < 64'(IMAGE_WIDTH) * 64'd256)
		else $error("map_x beyond one turn");
`endif

endmodule
